// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/epld_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge pair logo detector package
// Shared widths, codes and types of the logo detector.
// ----------------------------------------------------------------------------
package epld_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 8;
	localparam int CNT_OUT_W = 10;
	localparam int RUN_W     = 9;
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

	localparam logic [VERDICT_W-1:0] VERDICT_LOGO    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_NOLOGO  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LIMIT  = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] run_threshold;
		logic [CFG_W-1:0] edge_min;
		logic [CFG_W-1:0] bright_limit;
	} cfg_t;

	typedef struct packed {
		logic pass;
		logic unknown;
	} pair_flags_t;

endpackage

// ===== rtl/epld_pair_eval.sv =====
// ----------------------------------------------------------------------------
// Edge pair evaluation
// Classifies one test pair as passed, unknown (too bright) or plainly failed.
// ----------------------------------------------------------------------------
module epld_pair_eval (
	input  epld_pkg::cfg_t                 cfg,
	input  logic [epld_pkg::PIX_W-1:0]     rise_left,
	input  logic [epld_pkg::PIX_W-1:0]     rise_mid,
	input  logic [epld_pkg::PIX_W-1:0]     rise_right,
	input  logic [epld_pkg::PIX_W-1:0]     fall_left,
	input  logic [epld_pkg::PIX_W-1:0]     fall_mid,
	input  logic [epld_pkg::PIX_W-1:0]     fall_right,
	output epld_pkg::pair_flags_t          flags
);
	import epld_pkg::*;

	logic rise_ok;
	logic fall_ok;
	logic bright;

	// right - left >= edge_min, and right - left <= -edge_min, kept unsigned.
	assign rise_ok = {1'b0, rise_right} >= ({1'b0, rise_left} + {1'b0, cfg.edge_min});
	assign fall_ok = ({1'b0, fall_right} + {1'b0, cfg.edge_min}) <= {1'b0, fall_left};

	assign bright = (rise_left > cfg.bright_limit) || (rise_mid > cfg.bright_limit) ||
			(fall_left > cfg.bright_limit) || (fall_mid > cfg.bright_limit);

	assign flags.pass    = rise_ok && fall_ok;
	assign flags.unknown = !(rise_ok && fall_ok) && bright;

endmodule

// ===== rtl/edge_pair_logo_detector.sv =====
// ----------------------------------------------------------------------------
// Edge pair logo detector
// Per-frame logo verdict from luma edge test pairs, with hysteresis flag.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle. A beat enters an input register,
// its pair is classified and added to the frame counters in the next cycle,
// and a closing beat moves the frame counts into a verdict register, from
// which the verdict and the hysteresis run counters fill the output register.
// s_tready drops only while a closing beat waits behind a frame whose result
// has not been taken yet; beats that do not close a frame keep flowing
// meanwhile.
`include "assert_macros.svh"

module edge_pair_logo_detector #(
	parameter int PAIR_COUNT_MAX = 1023
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [epld_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [epld_pkg::CFG_W-1:0]         cfg_data,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// rise_left[7:0], rise_mid[15:8], rise_right[23:16],
	// fall_left[31:24], fall_mid[39:32], fall_right[47:40]
	input  logic [epld_pkg::S_TDATA_W-1:0]     s_tdata,
	// has_pair[0]
	input  logic                               s_tuser,
	// last_in_frame
	input  logic                               s_tlast,
	// Output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// verdict[1:0], logo_present[2], passed_pairs[12:3], total_pairs[22:13],
	// unknown_pairs[32:23], zero fill [39:33]
	output logic [epld_pkg::M_TDATA_W-1:0]     m_tdata
);
	import epld_pkg::*;

	localparam int CNT_W = $clog2(PAIR_COUNT_MAX + 1);
	localparam int CMP_W = CNT_W + 2;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAIR_COUNT_MAX);

	cfg_t cfg_q;

	// Input stage
	logic             valid_s1;
	logic             has_pair_s1;
	logic             last_s1;
	logic [PIX_W-1:0] rise_left_s1, rise_mid_s1, rise_right_s1;
	logic [PIX_W-1:0] fall_left_s1, fall_mid_s1, fall_right_s1;

	// Frame accumulators
	logic [CNT_W-1:0] total_q, passed_q, unknown_q;
	logic [CNT_W-1:0] total_nxt, passed_nxt, unknown_nxt;

	// Verdict stage
	logic             valid_s2;
	logic [CNT_W-1:0] total_s2, passed_s2, unknown_s2;

	// Hysteresis and output
	logic [RUN_W-1:0]     logo_run_q, nologo_run_q;
	logic                 logo_flag_q;
	logic [RUN_W-1:0]     logo_run_nxt, nologo_run_nxt;
	logic                 logo_flag_nxt;
	logic [RUN_W-1:0]     logo_run_inc, nologo_run_inc;
	logic [VERDICT_W-1:0] verdict;
	logic [CMP_W-1:0]     passed_x3, unknown_x3, total_ext;

	logic                 out_valid_q;
	logic [VERDICT_W-1:0] out_verdict_q;
	logic                 out_flag_q;
	logic [CNT_OUT_W-1:0] out_passed_q, out_total_q, out_unknown_q;

	pair_flags_t flags;

	logic out_free, s2_adv, s2_free, s1_move, s_accept;

	assign out_free = !out_valid_q || m_tready;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_move  = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || s1_move;
	assign s_accept = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_threshold <= 8'd1;
			cfg_q.edge_min      <= 8'd5;
			cfg_q.bright_limit  <= 8'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_THRESHOLD: cfg_q.run_threshold <= cfg_data;
				REG_EDGE_MIN:      cfg_q.edge_min      <= cfg_data;
				REG_BRIGHT_LIMIT:  cfg_q.bright_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			has_pair_s1   <= s_tuser;
			last_s1       <= s_tlast;
			rise_left_s1  <= s_tdata[7:0];
			rise_mid_s1   <= s_tdata[15:8];
			rise_right_s1 <= s_tdata[23:16];
			fall_left_s1  <= s_tdata[31:24];
			fall_mid_s1   <= s_tdata[39:32];
			fall_right_s1 <= s_tdata[47:40];
		end
	end

	epld_pair_eval u_pair_eval (
		.cfg        (cfg_q),
		.rise_left  (rise_left_s1),
		.rise_mid   (rise_mid_s1),
		.rise_right (rise_right_s1),
		.fall_left  (fall_left_s1),
		.fall_mid   (fall_mid_s1),
		.fall_right (fall_right_s1),
		.flags      (flags)
	);

	// Saturating frame counts including the beat in the input register.
	always_comb begin
		total_nxt   = total_q;
		passed_nxt  = passed_q;
		unknown_nxt = unknown_q;
		if (has_pair_s1) begin
			total_nxt = (total_q < CNT_MAX) ? total_q + CNT_W'(1) : CNT_MAX;
			if (flags.pass) begin
				passed_nxt = (passed_q < CNT_MAX) ? passed_q + CNT_W'(1) : CNT_MAX;
			end
			if (flags.unknown) begin
				unknown_nxt = (unknown_q < CNT_MAX) ? unknown_q + CNT_W'(1) : CNT_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			passed_q  <= '0;
			unknown_q <= '0;
		end else if (s1_move) begin
			if (last_s1) begin
				total_q   <= '0;
				passed_q  <= '0;
				unknown_q <= '0;
			end else begin
				total_q   <= total_nxt;
				passed_q  <= passed_nxt;
				unknown_q <= unknown_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			total_s2   <= total_nxt;
			passed_s2  <= passed_nxt;
			unknown_s2 <= unknown_nxt;
		end
	end

	// passed >= floor(total/3) is 3*passed + 3 > total, and
	// unknown > floor(total/3) is 3*unknown > total.
	assign total_ext  = CMP_W'(total_s2);
	assign passed_x3  = {1'b0, passed_s2, 1'b0} + CMP_W'(passed_s2) + CMP_W'(3);
	assign unknown_x3 = {1'b0, unknown_s2, 1'b0} + CMP_W'(unknown_s2);

	assign logo_run_inc   = (logo_run_q < RUN_MAX) ? logo_run_q + RUN_W'(1) : RUN_MAX;
	assign nologo_run_inc = (nologo_run_q < RUN_MAX) ? nologo_run_q + RUN_W'(1) : RUN_MAX;

	always_comb begin
		logo_run_nxt   = logo_run_q;
		nologo_run_nxt = nologo_run_q;
		logo_flag_nxt  = logo_flag_q;
		priority if (passed_x3 > total_ext) begin
			verdict      = VERDICT_LOGO;
			logo_run_nxt = logo_run_inc;
			if (logo_run_inc > RUN_W'(cfg_q.run_threshold)) begin
				logo_flag_nxt  = 1'b1;
				nologo_run_nxt = '0;
			end
		end else if (unknown_x3 > total_ext) begin
			verdict = VERDICT_UNKNOWN;
		end else begin
			verdict        = VERDICT_NOLOGO;
			nologo_run_nxt = nologo_run_inc;
			if (nologo_run_inc > RUN_W'(cfg_q.run_threshold)) begin
				logo_flag_nxt = 1'b0;
				logo_run_nxt  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logo_run_q   <= '0;
			nologo_run_q <= '0;
			logo_flag_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s2_adv) begin
				logo_run_q   <= logo_run_nxt;
				nologo_run_q <= nologo_run_nxt;
				logo_flag_q  <= logo_flag_nxt;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_verdict_q <= verdict;
			out_flag_q    <= logo_flag_nxt;
			out_passed_q  <= CNT_OUT_W'(passed_s2);
			out_total_q   <= CNT_OUT_W'(total_s2);
			out_unknown_q <= CNT_OUT_W'(unknown_s2);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_unknown_q, out_total_q, out_passed_q, out_flag_q,
			out_verdict_q};

	`ASSERT_PROP(a_frame_reaches_output, clk, arst_n, s2_adv |=> m_tvalid)
	`ASSERT_PROP(a_close_clears_counts, clk, arst_n,
		(s1_move && last_s1) |=> (total_q == '0 && passed_q == '0 && unknown_q == '0))
	`ASSERT_NEVER(a_stall_only_on_close, clk, arst_n,
		!s_tready && !(valid_s1 && last_s1 && valid_s2))
	`ASSERT_NEVER(a_counts_within_total, clk, arst_n,
		(passed_q > total_q) || (unknown_q > total_q))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge pair logo detector testbench
// Drives pair beats and frame closes into the detector, predicts each frame
// verdict with counts and hysteresis flag, and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import epld_pkg::*;

	localparam int PAIR_LIMIT = 1023;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int CLOSE_SLACK = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic             has_pair;
		logic [PIX_W-1:0] rise_left;
		logic [PIX_W-1:0] rise_mid;
		logic [PIX_W-1:0] rise_right;
		logic [PIX_W-1:0] fall_left;
		logic [PIX_W-1:0] fall_mid;
		logic [PIX_W-1:0] fall_right;
		logic             last;
	} pair_beat_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic                 logo_present;
		logic [CNT_OUT_W-1:0] passed;
		logic [CNT_OUT_W-1:0] total;
		logic [CNT_OUT_W-1:0] unknown;
	} frame_result_t;

	// Tracks the frame counters, run counters and flag, and holds the verdicts
	// that closed frames are still owed.
	class frame_verdict_board;
		cfg_t                 regs;
		logic [CNT_OUT_W-1:0] n_total;
		logic [CNT_OUT_W-1:0] n_passed;
		logic [CNT_OUT_W-1:0] n_unknown;
		logic [RUN_W-1:0]     logo_run;
		logic [RUN_W-1:0]     nologo_run;
		logic                 logo_flag;
		frame_result_t        expected_frames[$];
		int                   failures;

		function new();
			regs.run_threshold = 8'd1;
			regs.edge_min = 8'd5;
			regs.bright_limit = 8'd200;
			n_total = '0;
			n_passed = '0;
			n_unknown = '0;
			logo_run = '0;
			nologo_run = '0;
			logo_flag = 1'b0;
			failures = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			unique case (idx)
				REG_RUN_THRESHOLD: regs.run_threshold = val;
				REG_EDGE_MIN:      regs.edge_min = val;
				REG_BRIGHT_LIMIT:  regs.bright_limit = val;
				default: ;
			endcase
		endfunction

		function logic [CNT_OUT_W-1:0] bump_count(logic [CNT_OUT_W-1:0] v);
			return (v == PAIR_LIMIT) ? v : v + 1'b1;
		endfunction

		function logic [RUN_W-1:0] bump_run(logic [RUN_W-1:0] v);
			return (v == RUN_MAX) ? v : v + 1'b1;
		endfunction

		function void take_beat(pair_beat_t b);
			int rise_grad;
			int fall_grad;
			int em;
			int bl;
			logic [CNT_OUT_W-1:0] third;
			frame_result_t r;
			em = int'(regs.edge_min);
			bl = int'(regs.bright_limit);
			if (b.has_pair) begin
				rise_grad = int'(b.rise_right) - int'(b.rise_left);
				fall_grad = int'(b.fall_right) - int'(b.fall_left);
				n_total = bump_count(n_total);
				if (rise_grad >= em && fall_grad <= -em) begin
					n_passed = bump_count(n_passed);
				end else if (int'(b.rise_left) > bl || int'(b.rise_mid) > bl ||
						int'(b.fall_left) > bl || int'(b.fall_mid) > bl) begin
					n_unknown = bump_count(n_unknown);
				end
			end
			if (!b.last)
				return;
			third = CNT_OUT_W'(n_total / 3);
			if (n_passed >= third) begin
				r.verdict = VERDICT_LOGO;
				logo_run = bump_run(logo_run);
				if (logo_run > regs.run_threshold) begin
					logo_flag = 1'b1;
					nologo_run = '0;
				end
			end else if (n_unknown > third) begin
				r.verdict = VERDICT_UNKNOWN;
			end else begin
				r.verdict = VERDICT_NOLOGO;
				nologo_run = bump_run(nologo_run);
				if (nologo_run > regs.run_threshold) begin
					logo_flag = 1'b0;
					logo_run = '0;
				end
			end
			r.logo_present = logo_flag;
			r.passed = n_passed;
			r.total = n_total;
			r.unknown = n_unknown;
			expected_frames.push_back(r);
			n_total = '0;
			n_passed = '0;
			n_unknown = '0;
		endfunction

		function void check_verdict(logic [M_TDATA_W-1:0] d);
			frame_result_t got;
			frame_result_t want;
			got.verdict = d[1:0];
			got.logo_present = d[2];
			got.passed = d[12:3];
			got.total = d[22:13];
			got.unknown = d[32:23];
			if (expected_frames.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected verdict beat %h at %0t", d, $time);
				return;
			end
			want = expected_frames.pop_front();
			if (got.verdict !== want.verdict || got.logo_present !== want.logo_present ||
					got.passed !== want.passed || got.total !== want.total ||
					got.unknown !== want.unknown) begin
				failures++;
				if (failures <= 10)
					$display({"verdict mismatch at %0t: expected v%0d flag %0d p%0d t%0d u%0d,",
						" got v%0d flag %0d p%0d t%0d u%0d"}, $time,
						want.verdict, want.logo_present, want.passed, want.total,
						want.unknown, got.verdict, got.logo_present, got.passed,
						got.total, got.unknown);
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	frame_verdict_board board;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_left = 0;
	int stim_beats = 0;
	int cycle_count = 0;

	edge_pair_logo_detector #(
		.PAIR_COUNT_MAX(PAIR_LIMIT)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// Result side: checks accepted beats and stalls, either at random or for
	// a requested hold-off stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_verdict(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [PIX_W-1:0] clamp_pixel(int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[PIX_W-1:0];
	endfunction

	function automatic pair_beat_t beat_of(logic has, logic [7:0] rl, logic [7:0] rm,
			logic [7:0] rr, logic [7:0] fl, logic [7:0] fm, logic [7:0] fr, logic last);
		pair_beat_t b;
		b.has_pair = has;
		b.rise_left = rl;
		b.rise_mid = rm;
		b.rise_right = rr;
		b.fall_left = fl;
		b.fall_mid = fm;
		b.fall_right = fr;
		b.last = last;
		return b;
	endfunction

	function automatic pair_beat_t noise_beat(logic last);
		return beat_of(1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), last);
	endfunction

	// A passing pair is built inside the edge limits; other pairs are random
	// but often sit one step off the gradient and brightness boundaries.
	function automatic pair_beat_t make_pair(bit want_pass);
		pair_beat_t b;
		int em;
		int bl;
		em = int'(board.regs.edge_min);
		bl = int'(board.regs.bright_limit);
		b = noise_beat(1'b0);
		b.has_pair = 1'b1;
		if (want_pass) begin
			b.rise_left = PIX_W'($urandom_range(255 - em));
			b.rise_right = PIX_W'($urandom_range(255, int'(b.rise_left) + em));
			b.fall_left = PIX_W'($urandom_range(255, em));
			b.fall_right = PIX_W'($urandom_range(int'(b.fall_left) - em));
		end else begin
			if ($urandom_range(3) == 0)
				b.rise_left = clamp_pixel(bl + int'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				b.rise_mid = clamp_pixel(bl + int'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				b.fall_left = clamp_pixel(bl + int'($urandom_range(1)));
			if ($urandom_range(3) == 0)
				b.fall_mid = clamp_pixel(bl + int'($urandom_range(1)));
			if ($urandom_range(2) == 0)
				b.rise_right = clamp_pixel(int'(b.rise_left) + em - int'($urandom_range(1)));
			if ($urandom_range(2) == 0)
				b.fall_right = clamp_pixel(int'(b.fall_left) - em + int'($urandom_range(1)));
		end
		return b;
	endfunction

	task automatic send_beat(pair_beat_t b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= b.has_pair;
		s_tlast <= b.last;
		s_tdata <= {b.fall_right, b.fall_mid, b.fall_left,
			b.rise_right, b.rise_mid, b.rise_left};
		do
			@(posedge clk);
		while (!s_tready);
		board.take_beat(b);
		if (b.has_pair || b.last)
			stim_beats++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the block empty; pair beats may still be
	// inside it after the last verdict has left.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_drained();
		repeat (CLOSE_SLACK) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
	endtask

	// Pairs of one flat level; zero pairs gives an empty frame.
	task automatic send_flat_frame(int npairs, logic [7:0] level);
		if (npairs == 0)
			send_beat(beat_of(1'b0, level, level, level, level, level, level, 1'b1));
		for (int i = 0; i < npairs; i++)
			send_beat(beat_of(1'b1, level, level, level, level, level, level,
				i == npairs - 1));
	endtask

	task automatic send_frame(int npairs, int pass_pct);
		pair_beat_t b;
		bit bare_close;
		bare_close = (npairs == 0) || ($urandom_range(4) == 0);
		for (int i = 0; i < npairs; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(noise_beat(1'b0));
			b = make_pair($urandom_range(99) < pass_pct);
			b.last = !bare_close && (i == npairs - 1);
			send_beat(b);
		end
		if (bare_close)
			send_beat(noise_beat(1'b1));
	endtask

	task automatic send_random_frames(int beat_budget);
		int start;
		int npairs;
		int pass_pct;
		start = stim_beats;
		while (stim_beats - start < beat_budget) begin
			npairs = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
			pass_pct = 25 * $urandom_range(4);
			send_frame(npairs, pass_pct);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] em;
		logic [CFG_W-1:0] bl;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty frames, an ignored beat, boundary pairs and every verdict.
		send_flat_frame(0, 8'd0);
		send_beat(noise_beat(1'b0));
		send_flat_frame(0, 8'd0);
		send_beat(beat_of(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_beat(beat_of(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		send_beat(beat_of(1'b1, 8'd10, 8'd0, 8'd15, 8'd20, 8'd0, 8'd15, 1'b0));
		send_beat(beat_of(1'b1, 8'd10, 8'd201, 8'd14, 8'd20, 8'd0, 8'd15, 1'b0));
		send_beat(beat_of(1'b1, 8'd10, 8'd0, 8'd15, 8'd20, 8'd0, 8'd16, 1'b0));
		send_beat(beat_of(1'b1, 8'd0, 8'd200, 8'd255, 8'd255, 8'd200, 8'd0, 1'b1));
		send_beat(beat_of(1'b1, 8'd0, 8'd0, 8'd0, 8'd201, 8'd0, 8'd0, 1'b0));
		send_beat(beat_of(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd201, 8'd0, 1'b0));
		send_beat(beat_of(1'b1, 8'd201, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		send_flat_frame(3, 8'd0);
		send_flat_frame(3, 8'd0);

		// A write to an unused register index changes nothing.
		write_reg(REG_UNUSED, 8'hff);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			unique case (ph)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					thr = 8'($urandom_range(3));
					em = 8'($urandom_range(40));
					bl = 8'($urandom);
				end
				1: begin
					sender_idle_pct = 83;
					receiver_stall_pct = 0;
					thr = 8'd0;
					em = 8'd0;
					bl = 8'd0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 83;
					thr = 8'd255;
					em = 8'd255;
					bl = 8'd255;
				end
				default: begin
					sender_idle_pct = 11;
					receiver_stall_pct = 11;
					thr = 8'($urandom_range(4));
					em = 8'($urandom);
					bl = 8'($urandom);
				end
			endcase
			write_reg(REG_RUN_THRESHOLD, thr);
			write_reg(REG_EDGE_MIN, em);
			write_reg(REG_BRIGHT_LIMIT, bl);
			send_random_frames(50);
			if (ph == 0) begin
				// Results back up behind a long hold-off until the input stalls.
				hold_left = 60;
				repeat (30) send_flat_frame($urandom_range(2), 8'd0);
				wait_drained();
			end
			send_random_frames(50);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/epld_pkg.sv
rtl/epld_pair_eval.sv
rtl/edge_pair_logo_detector.sv
test/testbench.sv
